>>> rtl/core/assert_macros.svh
// Assertion macros shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Check that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

>>> rtl/core/ibt_pkg.sv
// Shared types and constants of the interval breakpoint table.
package ibt_pkg;
	localparam int unsigned ENTRIES_DEF  = 64;
	localparam int unsigned KEY_BITS_DEF = 32;
	localparam int unsigned VAL_BITS     = 8;
	localparam int unsigned FIELD_BITS   = 32;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // capture request, start old-table scan
		logic scan;     // advance the scan by one old entry
		logic emit_b;   // offer the begin breakpoint to the builder
		logic emit_e;   // offer the end breakpoint to the builder
		logic commit;   // swap in the rebuilt table
		logic respond;  // load the result register
	} ibt_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic empty_range;
		logic scan_last;  // the current scan index is the last old entry
		logic scan_none;  // old table has no entries
		logic over;       // rebuilt table exceeds capacity
	} ibt_sts_t;
endpackage

>>> rtl/core/ibt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ibt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/ibt_datapath.sv
// Datapath: two table banks, old-table scan, canonical rebuild, lookup.
module ibt_datapath #(
	parameter int unsigned ENTRIES  = ibt_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS = ibt_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ibt_pkg::ibt_cmd_t             cmd,
	output ibt_pkg::ibt_sts_t             sts,
	output logic                          hold_b,
	output logic                          hold_e,
	input  logic [ibt_pkg::VAL_BITS-1:0]  default_value,
	input  logic                          in_op,
	input  logic [ibt_pkg::FIELD_BITS-1:0] in_begin,
	input  logic [ibt_pkg::FIELD_BITS-1:0] in_end,
	input  logic [ibt_pkg::VAL_BITS-1:0]  in_value,
	input  logic [ibt_pkg::FIELD_BITS-1:0] in_key,
	output logic [ibt_pkg::VAL_BITS-1:0]  found_value,
	output logic [1:0]                    status
);
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned BW = $clog2(ENTRIES + 3);
	localparam int unsigned VB = ibt_pkg::VAL_BITS;

	// biased keys compare unsigned
	function automatic logic [KEY_BITS-1:0] bias(input logic [ibt_pkg::FIELD_BITS-1:0] raw);
		logic [KEY_BITS-1:0] k;
		k = KEY_BITS'(raw);
		k[KEY_BITS-1] = ~k[KEY_BITS-1];
		return k;
	endfunction

	logic              op_q;
	logic [KEY_BITS-1:0] b_q, e_q, q_q;
	logic [VB-1:0]     v_q;
	logic              bank_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_d;
	logic              rd_valid_q;
	logic [VB-1:0]     eval_q;    // value in effect at the end key
	logic [VB-1:0]     qval_q;    // value in effect at the query key
	logic [VB-1:0]     cur_q;     // last value kept in the rebuilt table
	logic [BW-1:0]     kept_q;
	logic              b_done_q, e_done_q;
	logic [VB-1:0]     found_q;
	logic [1:0]        status_q;

	logic [KEY_BITS-1:0] rk [2];
	logic [VB-1:0]       rv [2];
	logic                we [2];
	logic [KEY_BITS-1:0] wk;
	logic [VB-1:0]       wv;
	logic [AW-1:0]       waddr;

	// address the entry that the scan holds in the next cycle
	always_comb begin
		priority if (cmd.load) begin
			idx_d = '0;
		end else if (cmd.scan) begin
			idx_d = idx_q + AW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_bank
		ibt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key (
			.clk, .we(we[g]), .waddr, .wdata(wk), .raddr(idx_d), .rdata(rk[g]));
		ibt_ram #(.WIDTH(VB), .DEPTH(ENTRIES)) u_val (
			.clk, .we(we[g]), .waddr, .wdata(wv), .raddr(idx_d), .rdata(rv[g]));
	end

	logic [KEY_BITS-1:0] ok;
	logic [VB-1:0]       ov;
	assign ok = rk[bank_q];
	assign ov = rv[bank_q];

	// candidate breakpoint offered to the builder this cycle
	logic          cand;
	logic [KEY_BITS-1:0] ck;
	logic [VB-1:0] cv;
	logic          old_keep;

	assign old_keep = rd_valid_q && (ok < b_q || ok > e_q);

	always_comb begin
		cand = 1'b0;
		ck   = ok;
		cv   = ov;
		priority if (cmd.emit_b) begin
			cand = 1'b1; ck = b_q; cv = v_q;
		end else if (cmd.emit_e) begin
			cand = 1'b1; ck = e_q; cv = eval_q;
		end else if (rd_valid_q && !op_q) begin
			cand = old_keep;
		end
	end

	logic push;
	assign push  = cand && (cv != cur_q);
	assign wk    = ck;
	assign wv    = cv;
	assign waddr = AW'(kept_q);
	assign we[0] = push && bank_q && (kept_q < BW'(ENTRIES));
	assign we[1] = push && !bank_q && (kept_q < BW'(ENTRIES));

	// old entries below begin go before the begin breakpoint; the controller
	// emits begin once the scan reaches a key at or above it, or after the scan
	logic act;
	assign act    = !op_q && (b_q < e_q);
	assign hold_b = act && !b_done_q && (!rd_valid_q || !(ok < b_q));
	assign hold_e = act && !e_done_q && (!rd_valid_q || (ok > e_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.load) begin
				rd_valid_q <= (count_q != '0);
			end else if (cmd.scan) begin
				rd_valid_q <= 1'b1;
			end else if (!cmd.emit_b && !cmd.emit_e) begin
				rd_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				bank_q  <= ~bank_q;
				count_q <= CW'(kept_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			b_q      <= bias(in_begin);
			e_q      <= bias(in_end);
			q_q      <= bias(in_key);
			v_q      <= in_value;
			eval_q   <= default_value;
			qval_q   <= default_value;
			cur_q    <= default_value;
			kept_q   <= '0;
			b_done_q <= 1'b0;
			e_done_q <= 1'b0;
		end else begin
			if (rd_valid_q && !cmd.emit_b && !cmd.emit_e) begin
				if (ok <= e_q) eval_q <= ov;
				if (ok <= q_q) qval_q <= ov;
			end
			if (cmd.emit_b) b_done_q <= 1'b1;
			if (cmd.emit_e) e_done_q <= 1'b1;
			if (push) begin
				cur_q  <= cv;
				kept_q <= kept_q + BW'(1);
			end
		end
		if (cmd.respond) begin
			if (op_q == ibt_pkg::OP_LOOKUP) begin
				found_q  <= qval_q;
				status_q <= ibt_pkg::ST_DONE;
			end else begin
				found_q  <= '0;
				status_q <= !(b_q < e_q) ? ibt_pkg::ST_EMPTY :
				            (kept_q > BW'(ENTRIES)) ? ibt_pkg::ST_FULL :
				            ibt_pkg::ST_DONE;
			end
		end
	end

	assign found_value = found_q;
	assign status      = status_q;

	always_comb begin
		sts.is_lookup   = op_q;
		sts.empty_range = !(b_q < e_q);
		sts.scan_last   = (CW'(idx_q) + CW'(1)) >= count_q;
		sts.scan_none   = (count_q == '0);
		sts.over        = kept_q > BW'(ENTRIES);
	end
endmodule

>>> rtl/core/ibt_ctrl.sv
// Controller: sequences scan, rebuild and response of one request.
`include "assert_macros.svh"
module ibt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_busy,
	input  ibt_pkg::ibt_sts_t sts,
	input  logic              hold_b,
	input  logic              hold_e,
	output ibt_pkg::ibt_cmd_t cmd,
	output logic              idle
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_TAIL = 6'b000100,
		S_FIN  = 6'b001000,
		S_RESP = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   tail_e_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = sts.scan_none ? S_TAIL : S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (!sts.is_lookup && !sts.empty_range && hold_b) begin
					cmd.emit_b = 1'b1;
				end else if (!sts.is_lookup && !sts.empty_range && hold_e) begin
					cmd.emit_e = 1'b1;
				end else if (!sts.scan_last) begin
					cmd.scan = 1'b1;
				end else begin
					state_d = (sts.is_lookup || sts.empty_range) ? S_FIN : S_TAIL;
				end
			end
			S_TAIL: begin
				if (!hold_b && !hold_e) begin
					state_d = S_FIN;
				end else if (hold_b) begin
					cmd.emit_b = 1'b1;
				end else begin
					cmd.emit_e = 1'b1;
				end
			end
			S_FIN: begin
				if (!out_busy) begin
					cmd.respond = 1'b1;
					cmd.commit  = !sts.is_lookup && !sts.empty_range && !sts.over;
					state_d     = S_RESP;
				end
			end
			S_RESP: state_d = S_WAIT;
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tail_e_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			tail_e_q <= cmd.emit_e;
		end
	end

	assign idle = (state_q == S_IDLE);

	`CHK_IMPLY(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.emit_b, cmd.emit_e, cmd.scan, cmd.load}))
	`CHK_IMPLY(a_load_idle, clk, arst_n, cmd.load, state_q == S_IDLE)
	`CHK_NEXT(a_resp_next, clk, arst_n, cmd.respond, state_q == S_RESP)
	`CHK_IMPLY(a_commit_resp, clk, arst_n, cmd.commit, cmd.respond)
	`CHK_IMPLY(a_e_once, clk, arst_n, tail_e_q, !cmd.emit_e || state_q == S_TAIL || state_q == S_SCAN)
endmodule

>>> rtl/core/interval_breakpoint_table.sv
// Top level of the interval breakpoint table.
// Interval breakpoint table: a piecewise-constant map from signed keys to
// 8-bit values, held as a sorted table of (key, value) breakpoints in two
// ping-pong RAM banks. A lookup request returns the value in effect at
// query_key; an assign request writes new_value over [range_begin, range_end)
// and rebuilds the table in canonical form into the other bank, flagging
// status 2 and leaving the table untouched if it would overflow. One request
// is handled at a time, set by the one-entry-a-cycle scan of the old bank's
// read port, which pauses while a begin or end breakpoint is emitted; the
// response step waits while an earlier result on m_tdata is not yet taken.
// The result register loads in the response step, then resp_s1 is set and
// m_valid_q, which drives m_tvalid, follows it. The controller frees the
// input side once it has passed S_RESP and S_WAIT and is back in S_IDLE.
`include "assert_macros.svh"
module interval_breakpoint_table #(
	parameter int unsigned ENTRIES  = ibt_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS = ibt_pkg::KEY_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[0], range_begin[32:1], range_end[64:33], new_value[72:65],
	// query_key[104:73], zero fill to 112
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_value[7:0], status[9:8], zero fill to 16
	output logic [15:0]  m_tdata
);
	logic [ibt_pkg::VAL_BITS-1:0] default_q;
	logic in_fire, idle, m_valid_q, hold_b, hold_e;
	ibt_pkg::ibt_cmd_t cmd;
	ibt_pkg::ibt_sts_t sts;
	logic [ibt_pkg::VAL_BITS-1:0] found;
	logic [1:0] status;

	// hold the default register; it only takes effect on later requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (cfg_we) begin
			default_q <= cfg_wdata;
		end
	end

	assign s_tready = idle;
	assign in_fire  = s_tvalid && s_tready;

	// the datapath also raises the begin and end emit holds for the controller
	ibt_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.hold_b, .hold_e,
		.default_value(default_q),
		.in_op(s_tdata[0]),
		.in_begin(s_tdata[32:1]),
		.in_end(s_tdata[64:33]),
		.in_value(s_tdata[72:65]),
		.in_key(s_tdata[104:73]),
		.found_value(found),
		.status(status)
	);

	ibt_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.out_busy(m_valid_q && !m_tready),
		.sts, .hold_b, .hold_e, .cmd, .idle
	);

	// raise the output valid through resp_s1 in the cycle after the result register loads; drop it when m_tready takes it
	logic resp_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			resp_s1   <= 1'b0;
		end else begin
			resp_s1 <= cmd.respond;
			if (resp_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, status, found};

	`CHK_IMPLY(a_no_accept_busy, clk, arst_n, in_fire, !m_valid_q || m_tready || idle)
	`CHK_NEXT(a_resp_valid, clk, arst_n, resp_s1, m_valid_q)
	`CHK_IMPLY(a_stat_range, clk, arst_n, m_valid_q, m_tdata[9:8] != 2'd3)
endmodule
